// ===== hw/rtl/nsfb_pkg.sv =====
// nsfb_pkg: types and constants of the neighbor solicitation frame builder.
// No dependencies; imported by every module of the block.
package nsfb_pkg;

  localparam int unsigned FRAME_WORDS = 43;
  localparam int unsigned WIDX_W      = 6;
  localparam int unsigned CK_STEPS    = 21;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned ACC_W       = 21;
  localparam int unsigned PADDR_W     = 5;

  localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(FRAME_WORDS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CK_STEPS);

  // Sum of the fixed checksum words: ff02, 0001, ff00, length 32, next header 58,
  // type/code 8700 and option header 0101.
  localparam logic [ACC_W-1:0] CK_BASE = ACC_W'(32'h0002_865e);

  localparam logic [15:0] W_MCAST   = 16'h3333;
  localparam logic [15:0] W_ETYPE   = 16'h86dd;
  localparam logic [15:0] W_VER     = 16'h6000;
  localparam logic [15:0] W_PLEN    = 16'h0020;
  localparam logic [15:0] W_NH_HOP  = 16'h3aff;
  localparam logic [15:0] W_MC_PFX  = 16'hff02;
  localparam logic [15:0] W_MC_ONE  = 16'h0001;
  localparam logic [15:0] W_NS_TYPE = 16'h8700;
  localparam logic [15:0] W_OPT_HDR = 16'h0101;
  localparam logic [7:0]  B_SOL     = 8'hff;

  localparam logic [1:0] REG_OWN_MAC     = 2'd0;
  localparam logic [1:0] REG_OWN_IP_HIGH = 2'd1;
  localparam logic [1:0] REG_OWN_IP_LOW  = 2'd2;

  typedef struct packed {
    logic [63:0] target_high;
    logic [63:0] target_low;
  } in_req_t;

  typedef struct packed {
    logic [15:0] frame_word;
    logic        last_word;
  } out_rsp_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [63:0] own_ip_high;
    logic [63:0] own_ip_low;
  } cfg_t;

  typedef struct packed {
    in_req_t     target;
    logic [15:0] checksum;
  } job_t;

  function automatic logic [15:0] tgt_word(input in_req_t t, input logic [2:0] i);
    logic [127:0] a;
    a = {t.target_high, t.target_low};
    return a[127 - 16*i -: 16];
  endfunction

  function automatic logic [15:0] mac_word(input logic [47:0] m, input logic [1:0] i);
    logic [15:0] w;
    case (i)
      2'd0:    w = m[47:32];
      2'd1:    w = m[31:16];
      default: w = m[15:0];
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/nsfb_front.sv =====
// nsfb_front: accepts target requests and computes the ICMPv6 checksum.
// Depends on nsfb_pkg; feeds nsfb_queue.
module nsfb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsfb_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nsfb_pkg::in_req_t in_req_i,
  output logic             push_o,
  output nsfb_pkg::job_t   job_o,
  input  logic             full_i
);
  import nsfb_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  in_req_t           tgt_q, tgt_d;
  logic [15:0]       add_w;
  logic [16:0]       fold1;
  logic [16:0]       fold2;
  logic              done;
  logic              accept;

  assign done       = busy_q && (step_q == LAST_STEP);
  assign push_o     = done && !full_i;
  assign in_stall_o = busy_q && !push_o;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (step_q)
      5'd0, 5'd1, 5'd2, 5'd3:
        add_w = cfg_i.own_ip_high[63 - 16*step_q[1:0] -: 16];
      5'd4, 5'd5, 5'd6, 5'd7:
        add_w = cfg_i.own_ip_low[63 - 16*step_q[1:0] -: 16];
      5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
        add_w = tgt_word(tgt_q, step_q[2:0]);
      5'd16:   add_w = mac_word(cfg_i.own_mac, 2'd0);
      5'd17:   add_w = mac_word(cfg_i.own_mac, 2'd1);
      5'd18:   add_w = mac_word(cfg_i.own_mac, 2'd2);
      5'd19:   add_w = {8'h00, tgt_q.target_low[23:16]};
      5'd20:   add_w = tgt_q.target_low[15:0];
      default: add_w = 16'h0000;
    endcase
  end

  assign fold1 = {1'b0, acc_q[15:0]} + {12'h000, acc_q[ACC_W-1:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'h0000, fold1[16]};

  assign job_o.target   = tgt_q;
  assign job_o.checksum = ~fold2[15:0];

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    acc_d  = acc_q;
    tgt_d  = tgt_q;
    if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
      acc_d  = CK_BASE;
      tgt_d  = in_req_i;
    end else if (push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && !done) begin
      step_d = step_q + STEP_W'(1);
      acc_d  = acc_q + {5'd0, add_w};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    tgt_q <= tgt_d;
  end

endmodule

// ===== hw/rtl/nsfb_queue.sv =====
// nsfb_queue: two-entry queue of checksummed requests between front and back.
// Depends on nsfb_pkg.
module nsfb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nsfb_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output nsfb_pkg::job_t head_o
);
  import nsfb_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== hw/rtl/nsfb_back.sv =====
// nsfb_back: serializes one queued request into the 43 frame words.
// Depends on nsfb_pkg; drains nsfb_queue.
module nsfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nsfb_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  input  nsfb_pkg::job_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nsfb_pkg::out_rsp_t out_rsp_o
);
  import nsfb_pkg::*;

  logic [WIDX_W-1:0] idx_q, idx_d;
  logic              vld_q, vld_d;
  out_rsp_t          rsp_q, rsp_d;
  logic              advance;
  logic              emit;
  logic [15:0]       word;
  logic [7:0]        t13;
  logic [15:0]       t1415;

  assign t13     = head_i.target.target_low[23:16];
  assign t1415   = head_i.target.target_low[15:0];
  assign advance = !vld_q || !out_stall_i;
  assign emit    = advance && !empty_i;
  assign pop_o   = emit && (idx_q == LAST_WIDX);

  always_comb begin
    case (idx_q)
      6'd0:  word = W_MCAST;
      6'd1:  word = {B_SOL, t13};
      6'd2:  word = t1415;
      6'd3:  word = mac_word(cfg_i.own_mac, 2'd0);
      6'd4:  word = mac_word(cfg_i.own_mac, 2'd1);
      6'd5:  word = mac_word(cfg_i.own_mac, 2'd2);
      6'd6:  word = W_ETYPE;
      6'd7:  word = W_VER;
      6'd9:  word = W_PLEN;
      6'd10: word = W_NH_HOP;
      6'd11: word = cfg_i.own_ip_high[63:48];
      6'd12: word = cfg_i.own_ip_high[47:32];
      6'd13: word = cfg_i.own_ip_high[31:16];
      6'd14: word = cfg_i.own_ip_high[15:0];
      6'd15: word = cfg_i.own_ip_low[63:48];
      6'd16: word = cfg_i.own_ip_low[47:32];
      6'd17: word = cfg_i.own_ip_low[31:16];
      6'd18: word = cfg_i.own_ip_low[15:0];
      6'd19: word = W_MC_PFX;
      6'd24: word = W_MC_ONE;
      6'd25: word = {B_SOL, t13};
      6'd26: word = t1415;
      6'd27: word = W_NS_TYPE;
      6'd28: word = head_i.checksum;
      6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38:
        word = tgt_word(head_i.target, 3'(idx_q - 6'd31));
      6'd39: word = W_OPT_HDR;
      6'd40: word = mac_word(cfg_i.own_mac, 2'd0);
      6'd41: word = mac_word(cfg_i.own_mac, 2'd1);
      6'd42: word = mac_word(cfg_i.own_mac, 2'd2);
      default: word = 16'h0000;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    rsp_d = rsp_q;
    if (emit) begin
      vld_d            = 1'b1;
      rsp_d.frame_word = word;
      rsp_d.last_word  = (idx_q == LAST_WIDX);
      idx_d            = (idx_q == LAST_WIDX) ? '0 : idx_q + WIDX_W'(1);
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== hw/rtl/neighbor_solicitation_frame_builder_top.sv =====
// Top level of the neighbor solicitation frame builder: register port, front,
// queue and back. Depends on nsfb_pkg, nsfb_front, nsfb_queue, nsfb_back.
//
// Usage: each request on the input channel carries a 128-bit target IPv6
// address. The block answers with the 86-byte Ethernet frame of a neighbor
// solicitation as 43 big-endian 16-bit words; last_word marks the 43rd.
// The APB port holds own MAC (0x00), own IP upper half (0x08) and lower half
// (0x10); write them only while no frame is in flight.
// The front sums 21 checksum words one a cycle, then hands the request over to
// the queue, from which the back reads it.
// Throughput: one word per cycle while the output is not stalled, set by the
// output channel. A two-entry queue lets the front checksum the next request
// while the back is still sending a frame.
// Stall: a stalled output word is held; the front stalls the input while it sums
// a request, and also while its finished request waits on a full queue.
// Reset: the APB registers clear to zero, the queue empties, no output is valid.
module neighbor_solicitation_frame_builder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nsfb_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nsfb_pkg::out_rsp_t            out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nsfb_pkg::PADDR_W-1:0]  paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import nsfb_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  job_t       job;
  job_t       head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:3];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_OWN_MAC:     cfg_d.own_mac     = pwdata[47:0];
        REG_OWN_IP_HIGH: cfg_d.own_ip_high = pwdata;
        REG_OWN_IP_LOW:  cfg_d.own_ip_low  = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_MAC:     prdata = {16'h0000, cfg_q.own_mac};
      REG_OWN_IP_HIGH: prdata = cfg_q.own_ip_high;
      REG_OWN_IP_LOW:  prdata = cfg_q.own_ip_low;
      default:         prdata = 64'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nsfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .job_o      (job),
    .full_i     (full)
  );

  nsfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  nsfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== hw/rtl/nsfb_checker.sv =====
// nsfb_checker: port-level checks of the frame builder, bound to the top level.
// Depends on nsfb_pkg and neighbor_solicitation_frame_builder_top.
module nsfb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input nsfb_pkg::out_rsp_t out_rsp_i
);
  import nsfb_pkg::*;

  logic              out_acc;
  logic [WIDX_W-1:0] cnt_q;

  assign out_acc = out_valid_i && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_acc) begin
      cnt_q <= out_rsp_i.last_word ? '0 : cnt_q + WIDX_W'(1);
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> out_valid_i)
    else $error("output valid dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> $stable(out_rsp_i))
    else $error("stalled output word changed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (out_rsp_i.last_word == (cnt_q == LAST_WIDX)))
    else $error("last word flag not on the 43rd word");

  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && cnt_q == '0) |-> (out_rsp_i.frame_word == W_MCAST))
    else $error("frame does not open with multicast prefix");

  a_ethertype: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && cnt_q == WIDX_W'(6)) |-> (out_rsp_i.frame_word == W_ETYPE))
    else $error("ethertype word wrong");

endmodule

bind neighbor_solicitation_frame_builder_top nsfb_checker u_nsfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_i   (out_rsp_o)
);

// ===== tb/nsfb_frame_checker.sv =====
`timescale 1ns / 100ps
// nsfb_frame_checker: watches the target and frame channels and the register port,
// builds each expected solicitation frame and compares it word by word.
// Depends on nsfb_pkg.
module nsfb_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  nsfb_pkg::in_req_t            in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  nsfb_pkg::out_rsp_t           out_rsp_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [nsfb_pkg::PADDR_W-1:0] paddr_i,
  input  logic [63:0]                  pwdata_i,
  input  logic                         pready_i,
  output int                           mismatch_cnt_o,
  output int                           words_due_o
);
  import nsfb_pkg::*;

  typedef logic [15:0] frame_t [FRAME_WORDS];

  cfg_t     own_cfg;
  out_rsp_t frame_words_due[$];
  int       mismatches;

  function automatic frame_t build_frame(input cfg_t c, input in_req_t t);
    frame_t       w;
    logic [127:0] a;
    logic [31:0]  acc;
    a = {t.target_high, t.target_low};
    w[0] = 16'h3333;
    w[1] = {8'hff, a[23:16]};
    w[2] = a[15:0];
    for (int i = 0; i < 3; i++) begin
      w[3 + i]  = c.own_mac[47 - 16*i -: 16];
      w[40 + i] = c.own_mac[47 - 16*i -: 16];
    end
    w[6]  = 16'h86dd;
    w[7]  = 16'h6000;
    w[8]  = 16'h0000;
    w[9]  = 16'h0020;
    w[10] = 16'h3aff;
    for (int i = 0; i < 4; i++) begin
      w[11 + i] = c.own_ip_high[63 - 16*i -: 16];
      w[15 + i] = c.own_ip_low[63 - 16*i -: 16];
    end
    w[19] = 16'hff02;
    for (int i = 20; i < 24; i++) w[i] = 16'h0000;
    w[24] = 16'h0001;
    w[25] = {8'hff, a[23:16]};
    w[26] = a[15:0];
    w[27] = 16'h8700;
    w[28] = 16'h0000;
    w[29] = 16'h0000;
    w[30] = 16'h0000;
    for (int i = 0; i < 8; i++) w[31 + i] = a[127 - 16*i -: 16];
    w[39] = 16'h0101;
    // pseudo-header (addresses, length, next header) plus the message
    acc = 32'd32 + 32'd58;
    for (int i = 11; i < FRAME_WORDS; i++) acc += w[i];
    while (acc[31:16] != 16'h0) acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    w[28] = ~acc[15:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    frame_t   w;
    if (!rst_ni) begin
      own_cfg = '0;
      frame_words_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_words_due.size() == 0) begin
          $error("frame word %h with no request pending", out_rsp_i.frame_word);
          mismatches++;
        end else begin
          want = frame_words_due.pop_front();
          if (out_rsp_i.frame_word !== want.frame_word) begin
            $error("frame_word: expected %h, actual %h", want.frame_word,
                   out_rsp_i.frame_word);
            mismatches++;
          end
          if (out_rsp_i.last_word !== want.last_word) begin
            $error("last_word: expected %b, actual %b", want.last_word,
                   out_rsp_i.last_word);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        w = build_frame(own_cfg, in_req_i);
        for (int k = 0; k < FRAME_WORDS; k++)
          frame_words_due.push_back(out_rsp_t'{frame_word: w[k],
                                               last_word: (k == FRAME_WORDS - 1)});
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:3])
          REG_OWN_MAC:     own_cfg.own_mac = pwdata_i[47:0];
          REG_OWN_IP_HIGH: own_cfg.own_ip_high = pwdata_i;
          REG_OWN_IP_LOW:  own_cfg.own_ip_low = pwdata_i;
          default: ;
        endcase
      end
    end
    mismatch_cnt_o <= mismatches;
    words_due_o    <= frame_words_due.size();
  end

endmodule

// ===== tb/neighbor_solicitation_frame_builder_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the neighbor solicitation frame builder: clock, reset, register
// writes, target stimulus with random gaps and stalls, watchdog and verdict.
// Depends on nsfb_pkg, neighbor_solicitation_frame_builder_top, nsfb_frame_checker.
module neighbor_solicitation_frame_builder_top_tb;
  import nsfb_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  in_req_t            in_req;
  logic               out_valid;
  logic               out_stall;
  out_rsp_t           out_rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  int unsigned send_pct;
  int unsigned recv_pct;
  int unsigned hold_req_cnt;
  int          mismatch_cnt;
  int          words_due;

  neighbor_solicitation_frame_builder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  nsfb_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_req_i       (in_req),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_rsp_i      (out_rsp),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .mismatch_cnt_o (mismatch_cnt),
    .words_due_o    (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_target(input in_req_t t);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  function automatic in_req_t rand_target();
    in_req_t t;
    case ($urandom_range(7))
      0: begin
        t.target_high = $urandom_range(1) ? '1 : '0;
        t.target_low  = $urandom_range(1) ? '1 : '0;
      end
      1: begin
        t.target_high = 64'hff02_0000_0000_0000;
        t.target_low  = {40'h00_0000_01ff, 24'($urandom)};
      end
      default: begin
        t.target_high = {$urandom, $urandom};
        t.target_low  = {$urandom, $urandom};
      end
    endcase
    return t;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet == IDLE_LIMIT) begin
        $display("** neighbor_solicitation_frame_builder_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    in_valid     <= 1'b0;
    in_req       <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    send_pct     <= 29;
    recv_pct     <= 59;
    hold_req_cnt <= 0;
    rst_ni       <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset value
    send_target('0);
    // checksum sum folds to ffff, field goes out as 0000
    send_target(in_req_t'{target_high: 64'h799f_0000_0000_0000, target_low: '0});
    send_target('1);
    settle();

    // all ones; upper bits of the MAC write must be dropped
    cfg_write(REG_OWN_MAC, '1);
    cfg_write(REG_OWN_IP_HIGH, '1);
    cfg_write(REG_OWN_IP_LOW, '1);
    cfg_write(REG_SPARE, 64'h0123_4567_89ab_cdef);
    send_target('0);
    send_target('1);
    send_target(in_req_t'{target_high: 64'h5555_5555_5555_5555,
                          target_low:  64'haaaa_aaaa_aaaa_aaaa});
    send_target(in_req_t'{target_high: 64'haaaa_aaaa_aaaa_aaaa,
                          target_low:  64'h5555_5555_5555_5555});
    send_target(in_req_t'{target_high: 64'hff02_0000_0000_0000,
                          target_low:  64'h0000_0001_ff12_3456});
    send_target(in_req_t'{target_high: 64'hfe80_0000_0000_0000,
                          target_low:  64'h0211_22ff_fe33_4455});
    send_target(in_req_t'{target_high: '1, target_low: '0});
    send_target(in_req_t'{target_high: '0, target_low: '1});
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      send_pct <= (phase == 0) ? 29 : (phase == 1) ? 59 : 0;
      recv_pct <= (phase == 0) ? 59 : (phase == 1) ? 29 : 0;
      cfg_write(REG_OWN_MAC, {$urandom, $urandom});
      cfg_write(REG_OWN_IP_HIGH, {$urandom, $urandom});
      cfg_write(REG_OWN_IP_LOW, {$urandom, $urandom});
      cfg_write(REG_SPARE, {$urandom, $urandom});
      if (phase == 2) hold_req_cnt <= hold_req_cnt + 1;
      repeat (PHASE_ITEMS) send_target(rand_target());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && words_due == 0)
      $display("** neighbor_solicitation_frame_builder_top: PASSED **");
    else
      $display("** neighbor_solicitation_frame_builder_top: FAILED **");
    $finish;
  end

endmodule
